### rtl/glf_pkg.sv
package glf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;

    localparam logic [BYTE_W-1:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [BYTE_W-1:0] CH_G    = 8'h47;  // 'G'
    localparam logic [BYTE_W-1:0] CH_M    = 8'h4D;  // 'M'
    localparam logic [BYTE_W-1:0] CH_T    = 8'h54;  // 'T'
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;  // '\r'
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;  // '\n'

    // number of characters kept back from the line buffer size
    localparam int unsigned LINE_RESERVE = 2;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              line_end;
        logic              line_discard;
        logic              file_done;
    } glf_result_t;

endpackage

### rtl/glf_core.sv
module glf_core
    import glf_pkg::*;
#(
    parameter int unsigned MAX_LINE_CHARS = 96
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              last_byte,
    output logic              res_valid,
    output glf_result_t       res
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_LINE_CHARS - LINE_RESERVE);

    logic               in_comment_reg,     in_comment_next;
    logic               before_command_reg, before_command_next;
    logic [COUNT_W-1:0] char_count_reg,     char_count_next;

    logic               cmt_upd;
    logic               bc_upd;
    logic [COUNT_W-1:0] cnt_upd;
    logic               emit;
    logic               closed;
    logic               is_cmd_letter;

    always_comb
    begin
        cmt_upd       = in_comment_reg;
        bc_upd        = before_command_reg;
        cnt_upd       = char_count_reg;
        emit          = 1'b0;
        closed        = 1'b0;
        is_cmd_letter = (in_byte == CH_G) || (in_byte == CH_M) || (in_byte == CH_T);

        if (in_byte == CH_LF)
        begin
            emit    = (char_count_reg != '0);
            closed  = emit;
            cmt_upd = 1'b0;
            bc_upd  = 1'b1;
            cnt_upd = '0;
        end
        else if (char_count_reg >= FULL_COUNT)
        begin
            // line full: byte dropped
        end
        else if (in_byte == CH_SEMI)
        begin
            cmt_upd = 1'b1;
        end
        else
        begin
            if (is_cmd_letter)
            begin
                bc_upd = 1'b0;
            end
            if (!in_comment_reg && !bc_upd && (in_byte != CH_CR))
            begin
                emit    = 1'b1;
                cnt_upd = char_count_reg + COUNT_W'(1);
            end
        end

        res.out_byte     = emit ? (closed ? CH_LF : in_byte) : '0;
        res.byte_valid   = emit;
        res.line_end     = closed;
        res.line_discard = last_byte && (cnt_upd != '0);
        res.file_done    = last_byte;
        res_valid        = accept && (emit || last_byte);

        if (!accept)
        begin
            in_comment_next     = in_comment_reg;
            before_command_next = before_command_reg;
            char_count_next     = char_count_reg;
        end
        else if (last_byte)
        begin
            in_comment_next     = 1'b0;
            before_command_next = 1'b1;
            char_count_next     = '0;
        end
        else
        begin
            in_comment_next     = cmt_upd;
            before_command_next = bc_upd;
            char_count_next     = cnt_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_comment_reg     <= 1'b0;
            before_command_reg <= 1'b1;
            char_count_reg     <= '0;
        end
        else
        begin
            in_comment_reg     <= in_comment_next;
            before_command_reg <= before_command_next;
            char_count_reg     <= char_count_next;
        end
    end

endmodule

### rtl/glf_outbuf.sv
module glf_outbuf
    import glf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    input  glf_result_t wr_data,
    output logic        wr_ready,
    output logic        rd_valid,
    output glf_result_t rd_data,
    input  logic        rd_ready
);

    glf_result_t main_reg,       main_next;
    glf_result_t skid_reg,       skid_next;
    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    // ready only depends on the skid slot, so there is no combinational path from rd_ready
    assign wr_ready = !skid_valid_reg;
    assign rd_valid = main_valid_reg;
    assign rd_data  = main_reg;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (rd_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = wr_data;
                main_valid_next = wr_valid;
            end
        end
        else if (wr_valid)
        begin
            skid_next       = wr_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/gcode_line_filter.sv
// G-code line filter: takes one raw file byte per item on the slave stream and
// gives the kept command characters on the master stream. Leading text before
// the first G, M or T of a line, comments from ';', carriage returns and any
// character past MAX_LINE_CHARS-2 on a line are dropped; a newline closing a
// non-empty command comes out as '\n' with line_end set. The item carrying
// s_tlast always produces a result with m_tlast (file done) set, and
// line_discard set if a command was still open; the line state then returns
// to its reset values for the next file. Rate: one input item per cycle,
// sustained while s_tready is high; each result is registered in the output
// buffer before it is presented. The flag/count update is combinational, and a
// two-entry output buffer decouples the sides so s_tready drops only once two
// results are waiting on a stalled master.
module gcode_line_filter
    import glf_pkg::*;
#(
    parameter int unsigned MAX_LINE_CHARS = 96
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // last_byte

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic [2:0]        m_tuser,   // [0] byte_valid, [1] line_end, [2] line_discard
    output logic              m_tlast    // file_done
);

    logic        accept;
    logic        res_valid;
    glf_result_t res;
    glf_result_t out_res;

    assign accept = s_tvalid && s_tready;

    // per-line flags and character count
    glf_core #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register plus skid slot
    glf_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .wr_ready (s_tready),
        .rd_valid (m_tvalid),
        .rd_data  (out_res),
        .rd_ready (m_tready)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.line_discard, out_res.line_end, out_res.byte_valid};
    assign m_tlast = out_res.file_done;

`ifndef SYNTH
    // a closed command always carries the newline character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && (m_tdata == CH_LF)))
        else $error("line_end without newline");

    // discard only on the done item, never with a completed line
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tlast && !m_tuser[1]))
        else $error("line_discard outside file end");

    // a result that is neither a character nor a done mark must not appear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || m_tlast))
        else $error("empty result");

    // input stalls only while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("stalled with no pending result");
`endif

endmodule
